>>> src/gdc_pkg.sv
// Shared types, constants and calendar helpers for the Gregorian date calculator.
// No dependencies; used by gdc_ctrl, gdc_datapath and gregorian_date_calculator.
`timescale 1ns / 1ps
`default_nettype none

package gdc_pkg;

   localparam int OP_W    = 3;
   localparam int DAY_W   = 5;
   localparam int MON_W   = 4;
   localparam int YEAR_W  = 14;
   localparam int CNT_W   = 16;
   localparam int WDAY_W  = 3;
   localparam int CENT_W  = 8;
   localparam int REM_W   = 7;
   localparam int WSUM_W  = 15;

   localparam logic [OP_W-1:0] OP_CHECK = 3'd0;
   localparam logic [OP_W-1:0] OP_NEXT  = 3'd1;
   localparam logic [OP_W-1:0] OP_PREV  = 3'd2;
   localparam logic [OP_W-1:0] OP_ADD   = 3'd3;
   localparam logic [OP_W-1:0] OP_SUB   = 3'd4;
   localparam logic [OP_W-1:0] OP_WDAY  = 3'd5;

   localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1;
   localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;
   localparam logic [MON_W-1:0]  MON_JAN  = 4'd1;
   localparam logic [MON_W-1:0]  MON_FEB  = 4'd2;
   localparam logic [MON_W-1:0]  MON_MAR  = 4'd3;
   localparam logic [MON_W-1:0]  MON_DEC  = 4'd12;
   localparam logic [DAY_W-1:0]  DAY_FIRST = 5'd1;
   localparam logic [DAY_W-1:0]  DAY_LAST  = 5'd31;
   localparam logic [REM_W-1:0]  REM_LAST  = 7'd99;

   // floor(y / 100) == (y * RECIP_100) >> RECIP_100_SH for y < 2**14
   localparam int RECIP_100_W  = 13;
   localparam logic [RECIP_100_W-1:0] RECIP_100 = 13'd5243;
   localparam int RECIP_100_SH = 19;
   localparam int YPROD_W      = YEAR_W + RECIP_100_W;

   // floor(s / 7) == (s * RECIP_7) >> RECIP_7_SH for s < 2**15
   localparam int RECIP_7_W  = 16;
   localparam logic [RECIP_7_W-1:0] RECIP_7 = 16'd37450;
   localparam int RECIP_7_SH = 18;
   localparam int WPROD_W    = WSUM_W + RECIP_7_W;

   typedef struct packed {
      logic [OP_W-1:0]   opcode;
      logic [DAY_W-1:0]  day;
      logic [MON_W-1:0]  month;
      logic [YEAR_W-1:0] year;
      logic [CNT_W-1:0]  day_count;
   } req_type;

   typedef struct packed {
      logic [DAY_W-1:0]  out_day;
      logic [MON_W-1:0]  out_month;
      logic [YEAR_W-1:0] out_year;
      logic              date_valid;
      logic [WDAY_W-1:0] weekday;
      logic              range_error;
   } rsp_type;

   typedef struct packed {
      logic load;
      logic mul;
      logic split;
      logic eval;
      logic wmul;
      logic wfin;
      logic step;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic loop_add;
      logic loop_sub;
      logic step_done;
      logic out_free;
   } sts_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MON_W-1:0] m,
                                                  input logic leap);
      logic [DAY_W-1:0] len;
      case (m) inside
         4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
         MON_FEB:                 len = leap ? 5'd29 : 5'd28;
         default:                 len = 5'd31;
      endcase
      return len;
   endfunction

   // Sakamoto month offsets, January first
   function automatic logic [WDAY_W-1:0] month_key(input logic [MON_W-1:0] m);
      logic [WDAY_W-1:0] key;
      case (m)
         4'd1:    key = 3'd0;
         4'd2:    key = 3'd3;
         4'd3:    key = 3'd2;
         4'd4:    key = 3'd5;
         4'd5:    key = 3'd0;
         4'd6:    key = 3'd3;
         4'd7:    key = 3'd5;
         4'd8:    key = 3'd1;
         4'd9:    key = 3'd4;
         4'd10:   key = 3'd6;
         4'd11:   key = 3'd2;
         4'd12:   key = 3'd4;
         default: key = 3'd0;
      endcase
      return key;
   endfunction

endpackage

`default_nettype wire

>>> src/gregorian_date_calculator.sv
// Gregorian date calculator: check, next/previous day, add/subtract days, weekday.
// Every operation passes capture, year split, evaluation and the weekday steps;
//   add/subtract then run the one-month-per-cycle stepper until the day fits or the
//   date range ends. A new transaction is taken the cycle after the result moves into
//   the output register; a stalled output register delays that further.
// Reset: synchronous, active high; clears the sequencer and the output valid.
// Depends on gdc_pkg, gdc_ctrl and gdc_datapath.
`timescale 1ns / 1ps
`default_nettype none

module gregorian_date_calculator #(
   parameter int COUNT_BITS = 16
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  gdc_pkg::req_type req_data,
   output logic             rsp_valid,
   input  wire              rsp_stall,
   output gdc_pkg::rsp_type rsp_data
);

   gdc_pkg::cmd_type cmd;
   gdc_pkg::sts_type sts;
   gdc_pkg::rsp_type result;

   logic             loop_add;
   logic             loop_sub;
   logic             step_done;

   logic             rsp_valid_ff, rsp_valid_in;
   gdc_pkg::rsp_type rsp_data_ff, rsp_data_in;

   // The sequencer steps the datapath through: capture, year split by reciprocal
   // multiply, validity and single-day ops, weekday mod 7, add/subtract month loop.
   gdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   gdc_datapath #(
      .COUNT_BITS (COUNT_BITS)
   ) u_datapath (
      .clock     (clock),
      .req_data  (req_data),
      .cmd       (cmd),
      .loop_add  (loop_add),
      .loop_sub  (loop_sub),
      .step_done (step_done),
      .result    (result)
   );

   // The output register is free when empty or being taken this cycle.
   always_comb begin
      sts.loop_add  = loop_add;
      sts.loop_sub  = loop_sub;
      sts.step_done = step_done;
      sts.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.emit) begin
         // load a fresh transaction; the sequencer only emits when the slot is free
         rsp_valid_in = 1'b1;
         rsp_data_in  = result;
      end else if (!rsp_stall) begin
         // drop the transaction once the consumer has taken it
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> src/gdc_ctrl.sv
// Sequencer for the date calculator: walks one transaction through its steps.
// Depends on gdc_pkg (cmd_type, sts_type).
`timescale 1ns / 1ps
`default_nettype none

module gdc_ctrl (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_valid,
   output logic             req_stall,
   input  gdc_pkg::sts_type sts,
   output gdc_pkg::cmd_type cmd
);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_MUL   = 3'd1;
   localparam logic [2:0] S_SPLIT = 3'd2;
   localparam logic [2:0] S_EVAL  = 3'd3;
   localparam logic [2:0] S_WMUL  = 3'd4;
   localparam logic [2:0] S_WFIN  = 3'd5;
   localparam logic [2:0] S_LOOP  = 3'd6;
   localparam logic [2:0] S_OUT   = 3'd7;

   logic [2:0] state_ff;
   logic [2:0] state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_MUL;
            end
         end
         S_MUL: begin
            cmd.mul  = 1'b1;
            state_in = S_SPLIT;
         end
         S_SPLIT: begin
            cmd.split = 1'b1;
            state_in  = S_EVAL;
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            state_in = S_WMUL;
         end
         S_WMUL: begin
            cmd.wmul = 1'b1;
            state_in = S_WFIN;
         end
         S_WFIN: begin
            cmd.wfin = 1'b1;
            state_in = (sts.loop_add || sts.loop_sub) ? S_LOOP : S_OUT;
         end
         S_LOOP: begin
            cmd.step = 1'b1;
            if (sts.step_done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            // hold until the output register can take the result
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

>>> src/gdc_datapath.sv
// Datapath of the date calculator: date registers, leap and weekday logic, month stepper.
// Depends on gdc_pkg (types, constants, month_len, month_key).
`timescale 1ns / 1ps
`default_nettype none

module gdc_datapath #(
   parameter int COUNT_BITS = 16
) (
   input  wire              clock,
   input  gdc_pkg::req_type req_data,
   input  gdc_pkg::cmd_type cmd,
   output logic             loop_add,
   output logic             loop_sub,
   output logic             step_done,
   output gdc_pkg::rsp_type result
);

   localparam int ACC_W = COUNT_BITS + 2;

   logic [gdc_pkg::OP_W-1:0]    op_ff, op_in;
   logic [gdc_pkg::DAY_W-1:0]   day_ff, day_in;
   logic [gdc_pkg::MON_W-1:0]   mon_ff, mon_in;
   logic [gdc_pkg::YEAR_W-1:0]  year_ff, year_in;
   logic [COUNT_BITS-1:0]       cnt_ff, cnt_in;
   logic [gdc_pkg::YPROD_W-1:0] yprod_ff, yprod_in;
   logic [gdc_pkg::CENT_W-1:0]  cent_ff, cent_in;
   logic [gdc_pkg::REM_W-1:0]   rem_ff, rem_in;
   logic                        valid_ff, valid_in;
   logic [gdc_pkg::WSUM_W-1:0]  wsum_ff, wsum_in;
   logic [gdc_pkg::WPROD_W-1:0] wprod_ff, wprod_in;
   logic [gdc_pkg::WDAY_W-1:0]  wd_ff, wd_in;
   logic                        err_ff, err_in;
   logic                        add_ff, add_in;
   logic                        sub_ff, sub_in;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;

   logic [31:0]                 cnt_wide;
   logic [gdc_pkg::CENT_W-1:0]  quot;
   logic [gdc_pkg::YEAR_W-1:0]  quot100;
   logic                        leap;
   logic [gdc_pkg::DAY_W-1:0]   cur_len;
   logic [gdc_pkg::DAY_W-1:0]   prev_len;
   logic signed [ACC_W-1:0]     len_s;
   logic signed [ACC_W-1:0]     prev_len_s;
   logic                        date_ok;
   logic                        early;
   logic [gdc_pkg::YEAR_W-1:0]  ya;
   logic [gdc_pkg::CENT_W-1:0]  qa;
   logic [12:0]                 wquot;
   logic [15:0]                 wquot7;
   logic [15:0]                 wrem;
   logic                        add_fits;
   logic                        sub_fits;
   logic                        at_top;
   logic                        at_bottom;

   assign cnt_wide = 32'(req_data.day_count);

   // year split into century and remainder; century mod 4 lives in cent_ff[1:0]
   assign quot    = yprod_ff[gdc_pkg::YPROD_W-1:gdc_pkg::RECIP_100_SH];
   assign quot100 = gdc_pkg::YEAR_W'({quot, 6'b0}) + gdc_pkg::YEAR_W'({quot, 5'b0})
                  + gdc_pkg::YEAR_W'({quot, 2'b0});

   assign leap     = (year_ff[1:0] == 2'd0) && ((rem_ff != '0) || (cent_ff[1:0] == 2'd0));
   assign cur_len  = gdc_pkg::month_len(mon_ff, leap);
   assign prev_len = gdc_pkg::month_len(mon_ff - 4'd1, leap);
   assign len_s      = $signed(ACC_W'(cur_len));
   assign prev_len_s = $signed(ACC_W'(prev_len));

   assign date_ok = (mon_ff >= gdc_pkg::MON_JAN) && (mon_ff <= gdc_pkg::MON_DEC)
                 && (year_ff >= gdc_pkg::YEAR_MIN) && (year_ff <= gdc_pkg::YEAR_MAX)
                 && (day_ff != '0) && (day_ff <= cur_len);

   // January and February count toward the previous year
   assign early = (mon_ff < gdc_pkg::MON_MAR);
   assign ya    = early ? year_ff - 14'd1 : year_ff;
   assign qa    = (early && (rem_ff == '0)) ? cent_ff - 8'd1 : cent_ff;

   assign wquot  = wprod_ff[gdc_pkg::WPROD_W-1:gdc_pkg::RECIP_7_SH];
   assign wquot7 = 16'({wquot, 3'b0}) - 16'(wquot);
   assign wrem   = 16'(wsum_ff) - wquot7;

   assign add_fits  = (acc_ff <= len_s);
   assign sub_fits  = (acc_ff > $signed(ACC_W'(0)));
   assign at_top    = (mon_ff == gdc_pkg::MON_DEC) && (year_ff == gdc_pkg::YEAR_MAX);
   assign at_bottom = (mon_ff == gdc_pkg::MON_JAN) && (year_ff == gdc_pkg::YEAR_MIN);

   assign loop_add  = add_ff;
   assign loop_sub  = sub_ff;
   assign step_done = add_ff ? (add_fits || at_top) : (sub_fits || at_bottom);

   always_comb begin
      op_in    = op_ff;
      day_in   = day_ff;
      mon_in   = mon_ff;
      year_in  = year_ff;
      cnt_in   = cnt_ff;
      yprod_in = yprod_ff;
      cent_in  = cent_ff;
      rem_in   = rem_ff;
      valid_in = valid_ff;
      wsum_in  = wsum_ff;
      wprod_in = wprod_ff;
      wd_in    = wd_ff;
      err_in   = err_ff;
      add_in   = add_ff;
      sub_in   = sub_ff;
      acc_in   = acc_ff;

      if (cmd.load) begin
         op_in   = req_data.opcode;
         day_in  = req_data.day;
         mon_in  = req_data.month;
         year_in = req_data.year;
         cnt_in  = cnt_wide[COUNT_BITS-1:0];
      end

      if (cmd.mul) begin
         yprod_in = gdc_pkg::YPROD_W'(year_ff) * gdc_pkg::YPROD_W'(gdc_pkg::RECIP_100);
      end

      if (cmd.split) begin
         cent_in = quot;
         rem_in  = gdc_pkg::REM_W'(year_ff - quot100);
      end

      if (cmd.eval) begin
         valid_in = date_ok;
         err_in   = 1'b0;
         add_in   = 1'b0;
         sub_in   = 1'b0;
         wsum_in  = gdc_pkg::WSUM_W'(ya) + gdc_pkg::WSUM_W'(ya >> 2)
                  - gdc_pkg::WSUM_W'(qa) + gdc_pkg::WSUM_W'(qa >> 2)
                  + gdc_pkg::WSUM_W'(gdc_pkg::month_key(mon_ff))
                  + gdc_pkg::WSUM_W'(day_ff);
         if (date_ok) begin
            case (op_ff)
               gdc_pkg::OP_NEXT: begin
                  if (day_ff < cur_len) begin
                     day_in = day_ff + 5'd1;
                  end else if (mon_ff < gdc_pkg::MON_DEC) begin
                     day_in = gdc_pkg::DAY_FIRST;
                     mon_in = mon_ff + 4'd1;
                  end else if (year_ff < gdc_pkg::YEAR_MAX) begin
                     day_in  = gdc_pkg::DAY_FIRST;
                     mon_in  = gdc_pkg::MON_JAN;
                     year_in = year_ff + 14'd1;
                  end else begin
                     day_in = gdc_pkg::DAY_LAST;
                     err_in = 1'b1;
                  end
               end
               gdc_pkg::OP_PREV: begin
                  if (day_ff != gdc_pkg::DAY_FIRST) begin
                     day_in = day_ff - 5'd1;
                  end else if (mon_ff != gdc_pkg::MON_JAN) begin
                     mon_in = mon_ff - 4'd1;
                     day_in = prev_len;
                  end else if (year_ff > gdc_pkg::YEAR_MIN) begin
                     mon_in  = gdc_pkg::MON_DEC;
                     day_in  = gdc_pkg::DAY_LAST;
                     year_in = year_ff - 14'd1;
                  end else begin
                     err_in = 1'b1;
                  end
               end
               gdc_pkg::OP_ADD: begin
                  acc_in = $signed(ACC_W'(day_ff)) + $signed(ACC_W'(cnt_ff));
                  add_in = 1'b1;
               end
               gdc_pkg::OP_SUB: begin
                  acc_in = $signed(ACC_W'(day_ff)) - $signed(ACC_W'(cnt_ff));
                  sub_in = 1'b1;
               end
               default: begin
               end
            endcase
         end
      end

      if (cmd.wmul) begin
         wprod_in = gdc_pkg::WPROD_W'(wsum_ff) * gdc_pkg::WPROD_W'(gdc_pkg::RECIP_7);
      end

      if (cmd.wfin) begin
         wd_in = valid_ff ? wrem[gdc_pkg::WDAY_W-1:0] : '0;
      end

      if (cmd.step) begin
         if (add_ff) begin
            if (add_fits) begin
               day_in = acc_ff[gdc_pkg::DAY_W-1:0];
            end else if (at_top) begin
               // saturate at the last supported day
               day_in = gdc_pkg::DAY_LAST;
               err_in = 1'b1;
            end else begin
               acc_in = acc_ff - len_s;
               if (mon_ff == gdc_pkg::MON_DEC) begin
                  mon_in  = gdc_pkg::MON_JAN;
                  year_in = year_ff + 14'd1;
                  if (rem_ff == gdc_pkg::REM_LAST) begin
                     rem_in  = '0;
                     cent_in = cent_ff + 8'd1;
                  end else begin
                     rem_in = rem_ff + 7'd1;
                  end
               end else begin
                  mon_in = mon_ff + 4'd1;
               end
            end
         end else begin
            if (sub_fits) begin
               day_in = acc_ff[gdc_pkg::DAY_W-1:0];
            end else if (at_bottom) begin
               // saturate at the first supported day
               day_in = gdc_pkg::DAY_FIRST;
               err_in = 1'b1;
            end else if (mon_ff == gdc_pkg::MON_JAN) begin
               // December is 31 days whatever the year
               mon_in  = gdc_pkg::MON_DEC;
               year_in = year_ff - 14'd1;
               acc_in  = acc_ff + $signed(ACC_W'(gdc_pkg::DAY_LAST));
               if (rem_ff == '0) begin
                  rem_in  = gdc_pkg::REM_LAST;
                  cent_in = cent_ff - 8'd1;
               end else begin
                  rem_in = rem_ff - 7'd1;
               end
            end else begin
               mon_in = mon_ff - 4'd1;
               acc_in = acc_ff + prev_len_s;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      op_ff    <= op_in;
      day_ff   <= day_in;
      mon_ff   <= mon_in;
      year_ff  <= year_in;
      cnt_ff   <= cnt_in;
      yprod_ff <= yprod_in;
      cent_ff  <= cent_in;
      rem_ff   <= rem_in;
      valid_ff <= valid_in;
      wsum_ff  <= wsum_in;
      wprod_ff <= wprod_in;
      wd_ff    <= wd_in;
      err_ff   <= err_in;
      add_ff   <= add_in;
      sub_ff   <= sub_in;
      acc_ff   <= acc_in;
   end

   always_comb begin
      result.out_day     = day_ff;
      result.out_month   = mon_ff;
      result.out_year    = year_ff;
      result.date_valid  = valid_ff;
      result.weekday     = wd_ff;
      result.range_error = err_ff;
   end

endmodule

`default_nettype wire

>>> tb/testbench.sv
// Self-checking testbench for gregorian_date_calculator: directed and random date transactions.
// Holds its own calendar predictor and a scoreboard class; depends on gdc_pkg and the block.
`timescale 1ns / 1ps

module testbench;

   localparam int          COUNT_BITS = 16;
   localparam int unsigned COUNT_MASK = (1 << COUNT_BITS) - 1;
   localparam int          RANDOM_PER_PHASE = 56;
   localparam int          DRAIN_CYCLES = 20;
   // worst case is a full-count add or subtract through the stepper plus stalls, taken several times
   localparam int          CYCLE_LIMIT = 3_000_000;

   // opcode with no operation behind it; the block echoes the date
   localparam logic [gdc_pkg::OP_W-1:0] OP_UNUSED = 3'd7;

   // Sakamoto month offsets, January first
   localparam int unsigned WEEK_KEY[12] = '{0, 3, 2, 5, 0, 3, 5, 1, 4, 6, 2, 4};

   class calendar_scoreboard;
      gdc_pkg::rsp_type expected_dates[$];
      int unsigned      errors;

      function new();
         errors = 0;
      endfunction

      static function bit leap_year(int unsigned y);
         return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
      endfunction

      static function int unsigned days_in_month(int unsigned m, int unsigned y);
         case (m)
            4, 6, 9, 11:              return 30;
            2:                        return leap_year(y) ? 29 : 28;
            1, 3, 5, 7, 8, 10, 12:    return 31;
            default:                  return 0;
         endcase
      endfunction

      function gdc_pkg::rsp_type predict_date(gdc_pkg::req_type r);
         logic [gdc_pkg::OP_W-1:0] op;
         int unsigned              d, m, y, n, wd, ya;
         int                       acc;
         bit                       ok, err;
         gdc_pkg::rsp_type         res;
         op  = r.opcode;
         d   = r.day;
         m   = r.month;
         y   = r.year;
         n   = r.day_count & COUNT_MASK;
         wd  = 0;
         err = 0;
         ok  = (m >= 1) && (m <= 12) && (y >= gdc_pkg::YEAR_MIN) &&
               (y <= gdc_pkg::YEAR_MAX) && (d >= 1) && (d <= days_in_month(m, y));
         if (ok) begin
            ya = (m < 3) ? y - 1 : y;
            wd = (ya + ya / 4 - ya / 100 + ya / 400 + WEEK_KEY[m-1] + d) % 7;
            case (op)
               gdc_pkg::OP_NEXT: begin
                  if (d < days_in_month(m, y)) begin
                     d++;
                  end else begin
                     d = 1;
                     if (m < 12) begin
                        m++;
                     end else if (y < gdc_pkg::YEAR_MAX) begin
                        m = 1;
                        y++;
                     end else begin
                        d   = 31;
                        err = 1;
                     end
                  end
               end
               gdc_pkg::OP_PREV: begin
                  if (d != 1) begin
                     d--;
                  end else if (m != 1) begin
                     m--;
                     d = days_in_month(m, y);
                  end else if (y > gdc_pkg::YEAR_MIN) begin
                     m = 12;
                     d = 31;
                     y--;
                  end else begin
                     err = 1;
                  end
               end
               gdc_pkg::OP_ADD: begin
                  acc = int'(d + n);
                  forever begin
                     if (acc <= int'(days_in_month(m, y))) break;
                     acc -= int'(days_in_month(m, y));
                     m++;
                     if (m > 12) begin
                        m = 1;
                        y++;
                        if (y > gdc_pkg::YEAR_MAX) begin
                           y   = gdc_pkg::YEAR_MAX;
                           m   = 12;
                           acc = 31;
                           err = 1;
                           break;
                        end
                     end
                  end
                  d = acc;
               end
               gdc_pkg::OP_SUB: begin
                  acc = int'(d) - int'(n);
                  while (acc <= 0) begin
                     if (m == 1) begin
                        if (y == gdc_pkg::YEAR_MIN) begin
                           m   = 1;
                           acc = 1;
                           err = 1;
                           break;
                        end
                        m = 12;
                        y--;
                     end else begin
                        m--;
                     end
                     acc += int'(days_in_month(m, y));
                  end
                  d = acc;
               end
               default: ;
            endcase
         end
         res.out_day     = d[gdc_pkg::DAY_W-1:0];
         res.out_month   = m[gdc_pkg::MON_W-1:0];
         res.out_year    = y[gdc_pkg::YEAR_W-1:0];
         res.date_valid  = ok;
         res.weekday     = wd[gdc_pkg::WDAY_W-1:0];
         res.range_error = err;
         return res;
      endfunction

      function void note_request(gdc_pkg::req_type r);
         expected_dates.push_back(predict_date(r));
      endfunction

      function void compare_field(string name, int unsigned want, int unsigned got);
         if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         end
      endfunction

      function void check_response(gdc_pkg::rsp_type actual);
         gdc_pkg::rsp_type want;
         if (expected_dates.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none, actual %p", $time, actual);
            return;
         end
         want = expected_dates.pop_front();
         compare_field("out_day",     want.out_day,     actual.out_day);
         compare_field("out_month",   want.out_month,   actual.out_month);
         compare_field("out_year",    want.out_year,    actual.out_year);
         compare_field("date_valid",  want.date_valid,  actual.date_valid);
         compare_field("weekday",     want.weekday,     actual.weekday);
         compare_field("range_error", want.range_error, actual.range_error);
      endfunction

      function int pending();
         return expected_dates.size();
      endfunction
   endclass

   logic             clock     = 1'b0;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   gdc_pkg::req_type req_data  = '0;
   logic             rsp_stall = 1'b0;
   logic             req_stall;
   logic             rsp_valid;
   gdc_pkg::rsp_type rsp_data;

   // percent chance per cycle that the sender idles or the receiver stalls
   int unsigned idle_pct  = 0;
   int unsigned stall_pct = 0;

   calendar_scoreboard scoreboard = new();

   gregorian_date_calculator #(
      .COUNT_BITS(COUNT_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always #5 clock = ~clock;

   // Drive receiver back-pressure on the falling edge; hold it low during reset.
   always @(negedge clock) begin
      rsp_stall <= !reset && ($urandom_range(99) < stall_pct);
   end

   // Sample both channels at the rising edge: a transaction moves when valid is
   // high and stall is low. Predict on the input side, check on the output side.
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) scoreboard.note_request(req_data);
         if (rsp_valid && !rsp_stall) scoreboard.check_response(rsp_data);
      end
   end

   // Present one transaction, starting at a falling edge. Idle first at random,
   // then hold the payload until it is accepted and return at the next falling
   // edge with valid still high, so back-to-back transactions never drop valid.
   task automatic push_request(input gdc_pkg::req_type r);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_data  <= r;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      @(negedge clock);
   endtask

   task automatic send_date(input logic [gdc_pkg::OP_W-1:0] op, input int unsigned d,
                            input int unsigned m, input int unsigned y,
                            input int unsigned n);
      gdc_pkg::req_type r;
      r.opcode    = op;
      r.day       = d[gdc_pkg::DAY_W-1:0];
      r.month     = m[gdc_pkg::MON_W-1:0];
      r.year      = y[gdc_pkg::YEAR_W-1:0];
      r.day_count = n[gdc_pkg::CNT_W-1:0];
      push_request(r);
   endtask

   // Mostly well-formed dates with random content, biased toward the calendar
   // edges; the rest is raw noise over every bit of every field.
   function automatic gdc_pkg::req_type random_request();
      gdc_pkg::req_type r;
      int unsigned      dim;
      int unsigned      leap_edges[6] = '{1600, 1700, 1900, 2000, 2100, 2400};
      if ($urandom_range(99) < 15) begin
         r.opcode    = gdc_pkg::OP_W'($urandom_range(7, 0));
         r.day       = gdc_pkg::DAY_W'($urandom_range(31, 0));
         r.month     = gdc_pkg::MON_W'($urandom_range(15, 0));
         r.year      = gdc_pkg::YEAR_W'($urandom_range(16383, 0));
         r.day_count = gdc_pkg::CNT_W'($urandom_range(65535, 0));
         return r;
      end
      r.opcode = gdc_pkg::OP_W'($urandom_range(gdc_pkg::OP_WDAY, gdc_pkg::OP_CHECK));
      case ($urandom_range(5, 0))
         0:       r.year = gdc_pkg::YEAR_W'($urandom_range(3, 1));
         1:       r.year = gdc_pkg::YEAR_W'($urandom_range(9999, 9997));
         2:       r.year = gdc_pkg::YEAR_W'(leap_edges[$urandom_range(5, 0)]);
         default: r.year = gdc_pkg::YEAR_W'($urandom_range(9999, 1));
      endcase
      r.month = gdc_pkg::MON_W'($urandom_range(12, 1));
      dim     = calendar_scoreboard::days_in_month(r.month, r.year);
      case ($urandom_range(4, 0))
         0:       r.day = gdc_pkg::DAY_W'(1);
         1:       r.day = gdc_pkg::DAY_W'(dim);
         2:       r.day = gdc_pkg::DAY_W'($urandom_range(31, 1));
         default: r.day = gdc_pkg::DAY_W'($urandom_range(dim, 1));
      endcase
      // keep most counts short; the stepper walks one month per cycle
      case ($urandom_range(9, 0))
         0:       r.day_count = gdc_pkg::CNT_W'($urandom_range(65535, 0));
         1:       r.day_count = gdc_pkg::CNT_W'($urandom_range(40, 0));
         default: r.day_count = gdc_pkg::CNT_W'($urandom_range(400, 0));
      endcase
      return r;
   endfunction

   // Hard stop on a hung design.
   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("testbench failed");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0:       begin idle_pct = 0;  stall_pct = 0;  end
            1:       begin idle_pct = 71; stall_pct = 0;  end
            2:       begin idle_pct = 0;  stall_pct = 71; end
            default: begin idle_pct = 28; stall_pct = 28; end
         endcase
         if (phase == 0) begin
            // validity: leap rules and malformed fields
            send_date(gdc_pkg::OP_CHECK, 29, 2, 2000, 0);
            send_date(gdc_pkg::OP_CHECK, 29, 2, 1900, 0);
            send_date(gdc_pkg::OP_CHECK, 31, 4, 2023, 0);
            send_date(gdc_pkg::OP_CHECK, 0, 5, 2023, 0);
            send_date(gdc_pkg::OP_CHECK, 10, 0, 2023, 0);
            send_date(gdc_pkg::OP_CHECK, 10, 15, 2023, 0);
            send_date(gdc_pkg::OP_CHECK, 10, 6, 0, 0);
            send_date(gdc_pkg::OP_CHECK, 31, 12, 16383, 65535);
            // next day: month, year and leap rollovers, overflow past the last year
            send_date(gdc_pkg::OP_NEXT, 28, 2, 2024, 0);
            send_date(gdc_pkg::OP_NEXT, 28, 2, 2023, 0);
            send_date(gdc_pkg::OP_NEXT, 31, 12, 2023, 0);
            send_date(gdc_pkg::OP_NEXT, 31, 12, 9999, 0);
            // previous day: into February, across the year, underflow before year one
            send_date(gdc_pkg::OP_PREV, 1, 3, 2024, 0);
            send_date(gdc_pkg::OP_PREV, 1, 1, 2024, 0);
            send_date(gdc_pkg::OP_PREV, 1, 1, 1, 0);
            // add: zero, full count from the first date, overflow
            send_date(gdc_pkg::OP_ADD, 31, 1, 2023, 0);
            send_date(gdc_pkg::OP_ADD, 31, 1, 2024, 29);
            send_date(gdc_pkg::OP_ADD, 1, 1, 1, 65535);
            send_date(gdc_pkg::OP_ADD, 31, 12, 9999, 1);
            // subtract: zero, stepping back into shorter months, underflow
            send_date(gdc_pkg::OP_SUB, 31, 3, 2024, 0);
            send_date(gdc_pkg::OP_SUB, 31, 3, 2023, 31);
            send_date(gdc_pkg::OP_SUB, 31, 12, 9999, 65535);
            send_date(gdc_pkg::OP_SUB, 1, 1, 1, 1);
            // weekday and an unused opcode
            send_date(gdc_pkg::OP_WDAY, 1, 1, 2000, 0);
            send_date(OP_UNUSED, 15, 8, 1987, 100);
         end
         repeat (RANDOM_PER_PHASE) push_request(random_request());
      end
      req_valid <= 1'b0;

      // Drain the results still in flight, then watch for strays.
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (scoreboard.errors == 0 && scoreboard.pending() == 0) begin
         $display("testbench passed");
      end else begin
         $display("testbench failed");
      end
      $finish;
   end

endmodule
